/* design/fps_pkg.sv */
// Shared types, constants and helpers for the flight phase sequencer.
// No dependencies; used by fps_cfg, fps_seq and flight_phase_sequencer_core.
`timescale 1ns / 1ps

package fps_pkg;

    // Field widths
    localparam int ALT_W   = 18;
    localparam int VEL_W   = 17;
    localparam int THR_W   = 14;
    localparam int PCT_W   = 7;
    localparam int REL_W   = 14;
    localparam int SPD_W   = 10;
    localparam int PHASE_W = 3;
    localparam int PEAK_W  = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    // Input saturation limits
    localparam logic signed [ALT_W-1:0] ALT_MIN = -18'sd20000;
    localparam logic signed [ALT_W-1:0] ALT_MAX = 18'sd100000;
    localparam logic signed [VEL_W-1:0] VEL_MIN = -17'sd50000;
    localparam logic signed [VEL_W-1:0] VEL_MAX = 17'sd50000;

    // Register limits and reset values
    localparam logic [THR_W-1:0] THR_MAX   = 14'd10000;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [REL_W-1:0] REL_MAX   = 14'd10000;
    localparam logic [SPD_W-1:0] SPD_MAX   = 10'd1000;
    localparam logic [THR_W-1:0] THR_RESET = 14'd50;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd80;
    localparam logic [REL_W-1:0] REL_RESET = 14'd20;
    localparam logic [SPD_W-1:0] SPD_RESET = 10'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ASCENT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENT_PERCENT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_ALTITUDE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LANDED_SPEED     = 2'd3;

    // Phase codes as seen on the result bus
    localparam logic [PHASE_W-1:0] PHASE_CODE_PRELAUNCH = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_PAD       = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_ASCENT    = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_APOGEE    = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DESCENT   = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_CODE_PROBE     = 3'd5;
    localparam logic [PHASE_W-1:0] PHASE_CODE_PAYLOAD   = 3'd6;
    localparam logic [PHASE_W-1:0] PHASE_CODE_LANDED    = 3'd7;

    typedef enum logic [7:0] {
        PH_PRELAUNCH = 8'b0000_0001,
        PH_PAD       = 8'b0000_0010,
        PH_ASCENT    = 8'b0000_0100,
        PH_APOGEE    = 8'b0000_1000,
        PH_DESCENT   = 8'b0001_0000,
        PH_PROBE     = 8'b0010_0000,
        PH_PAYLOAD   = 8'b0100_0000,
        PH_LANDED    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [THR_W-1:0] ascent_threshold;
        logic [PCT_W-1:0] descent_percent;
        logic [REL_W-1:0] release_altitude;
        logic [SPD_W-1:0] landed_speed;
    } cfg_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] altitude;
        logic signed [VEL_W-1:0] vertical_speed;
        logic                    link_up;
        logic                    clock_set;
    } item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               zero_request;
        logic               servo_reset;
        logic               cam_one_start;
        logic               cam_two_start;
        logic               cam_one_stop;
        logic               cam_two_stop;
    } result_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        case (p)
            PH_PRELAUNCH: phase_code = PHASE_CODE_PRELAUNCH;
            PH_PAD:       phase_code = PHASE_CODE_PAD;
            PH_ASCENT:    phase_code = PHASE_CODE_ASCENT;
            PH_APOGEE:    phase_code = PHASE_CODE_APOGEE;
            PH_DESCENT:   phase_code = PHASE_CODE_DESCENT;
            PH_PROBE:     phase_code = PHASE_CODE_PROBE;
            PH_PAYLOAD:   phase_code = PHASE_CODE_PAYLOAD;
            PH_LANDED:    phase_code = PHASE_CODE_LANDED;
            default:      phase_code = PHASE_CODE_PRELAUNCH;
        endcase
    endfunction

endpackage

/* design/fps_cfg.sv */
// Configuration register file for the flight phase sequencer.
// Depends on fps_pkg for widths, limits, reset values and register indexes.
`timescale 1ns / 1ps

module fps_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [fps_pkg::CFG_IDX_W-1:0]   index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]  wdata,
    output fps_pkg::cfg_t                   cfg
);

    logic [fps_pkg::THR_W-1:0] thr_reg, thr_next;
    logic [fps_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic [fps_pkg::REL_W-1:0] rel_reg, rel_next;
    logic [fps_pkg::SPD_W-1:0] spd_reg, spd_next;

    logic [fps_pkg::THR_W-1:0] thr_raw;
    logic [fps_pkg::PCT_W-1:0] pct_raw;
    logic [fps_pkg::REL_W-1:0] rel_raw;
    logic [fps_pkg::SPD_W-1:0] spd_raw;

    // Truncate to register width, then clamp to the register maximum
    assign thr_raw = wdata[fps_pkg::THR_W-1:0];
    assign pct_raw = wdata[fps_pkg::PCT_W-1:0];
    assign rel_raw = wdata[fps_pkg::REL_W-1:0];
    assign spd_raw = wdata[fps_pkg::SPD_W-1:0];

    always_comb
    begin
        thr_next = thr_reg;
        pct_next = pct_reg;
        rel_next = rel_reg;
        spd_next = spd_reg;
        if (wr_en)
        begin
            case (index)
                fps_pkg::REG_ASCENT_THRESHOLD:
                    thr_next = (thr_raw > fps_pkg::THR_MAX) ? fps_pkg::THR_MAX : thr_raw;
                fps_pkg::REG_DESCENT_PERCENT:
                    pct_next = (pct_raw > fps_pkg::PCT_MAX) ? fps_pkg::PCT_MAX : pct_raw;
                fps_pkg::REG_RELEASE_ALTITUDE:
                    rel_next = (rel_raw > fps_pkg::REL_MAX) ? fps_pkg::REL_MAX : rel_raw;
                fps_pkg::REG_LANDED_SPEED:
                    spd_next = (spd_raw > fps_pkg::SPD_MAX) ? fps_pkg::SPD_MAX : spd_raw;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= fps_pkg::THR_RESET;
            pct_reg <= fps_pkg::PCT_RESET;
            rel_reg <= fps_pkg::REL_RESET;
            spd_reg <= fps_pkg::SPD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
            pct_reg <= pct_next;
            rel_reg <= rel_next;
            spd_reg <= spd_next;
        end
    end

    assign cfg.ascent_threshold = thr_reg;
    assign cfg.descent_percent  = pct_reg;
    assign cfg.release_altitude = rel_reg;
    assign cfg.landed_speed     = spd_reg;

endmodule

/* design/fps_seq.sv */
// Flight phase state machine, peak/pad tracking and camera latches.
// Depends on fps_pkg for the item, result, config and phase types.
`timescale 1ns / 1ps

module fps_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  fps_pkg::cfg_t    cfg,
    input  fps_pkg::item_t   item,
    output fps_pkg::result_t result
);

    fps_pkg::phase_t phase_reg, phase_next;
    logic [fps_pkg::PEAK_W-1:0]       peak_reg, peak_next;
    logic signed [fps_pkg::ALT_W-1:0] pad_alt_reg, pad_alt_next;
    logic pad_ready_reg, pad_ready_next;
    logic apogee_seen_reg, apogee_seen_next;
    logic cam_one_running_reg, cam_one_running_next;
    logic cam_two_running_reg, cam_two_running_next;

    logic signed [fps_pkg::ALT_W-1:0] alt;
    logic signed [fps_pkg::VEL_W-1:0] vel;
    logic signed [fps_pkg::VEL_W-1:0] vel_neg;
    logic [15:0]                      speed_mag;
    logic signed [fps_pkg::ALT_W:0]   ascent_level;
    logic signed [24:0]               alt_x100;
    logic [23:0]                      pct_peak;
    logic hit_ascent;
    logic hit_descent;
    logic hit_release;
    logic hit_landed;
    logic above_peak;

    // Saturate the inputs
    always_comb
    begin
        if (item.altitude < fps_pkg::ALT_MIN)
            alt = fps_pkg::ALT_MIN;
        else if (item.altitude > fps_pkg::ALT_MAX)
            alt = fps_pkg::ALT_MAX;
        else
            alt = item.altitude;

        if (item.vertical_speed < fps_pkg::VEL_MIN)
            vel = fps_pkg::VEL_MIN;
        else if (item.vertical_speed > fps_pkg::VEL_MAX)
            vel = fps_pkg::VEL_MAX;
        else
            vel = item.vertical_speed;
    end

    assign vel_neg   = -vel;
    assign speed_mag = vel[fps_pkg::VEL_W-1] ? vel_neg[15:0] : vel[15:0];

    assign ascent_level = {pad_alt_reg[fps_pkg::ALT_W-1], pad_alt_reg}
                        + $signed({5'b0, cfg.ascent_threshold});
    assign hit_ascent   = $signed({alt[fps_pkg::ALT_W-1], alt}) >= ascent_level;

    // Percent compare by cross-multiplication: alt * 100 <= pct * peak
    assign alt_x100    = $signed({{7{alt[fps_pkg::ALT_W-1]}}, alt}) * 25'sd100;
    assign pct_peak    = {17'b0, cfg.descent_percent} * {7'b0, peak_reg};
    assign hit_descent = alt_x100 <= $signed({1'b0, pct_peak});

    assign hit_release = $signed({alt[fps_pkg::ALT_W-1], alt})
                         <= $signed({5'b0, cfg.release_altitude});
    assign hit_landed  = speed_mag < {6'b0, cfg.landed_speed};
    assign above_peak  = alt > $signed({1'b0, peak_reg});

    always_comb
    begin
        phase_next           = phase_reg;
        peak_next            = peak_reg;
        pad_alt_next         = pad_alt_reg;
        pad_ready_next       = pad_ready_reg;
        apogee_seen_next     = apogee_seen_reg;
        cam_one_running_next = cam_one_running_reg;
        cam_two_running_next = cam_two_running_reg;
        result               = '0;

        case (phase_reg)
            fps_pkg::PH_PRELAUNCH:
            begin
                if (item.link_up && item.clock_set)
                begin
                    phase_next     = fps_pkg::PH_PAD;
                    pad_ready_next = 1'b0;
                end
            end
            fps_pkg::PH_PAD:
            begin
                if (!pad_ready_reg)
                begin
                    result.zero_request  = 1'b1;
                    result.servo_reset   = 1'b1;
                    cam_one_running_next = 1'b0;
                    cam_two_running_next = 1'b0;
                    pad_alt_next         = alt;
                    pad_ready_next       = 1'b1;
                end
                else if (hit_ascent)
                begin
                    phase_next = fps_pkg::PH_ASCENT;
                end
            end
            fps_pkg::PH_ASCENT:
            begin
                if (above_peak)
                    peak_next = alt[fps_pkg::PEAK_W-1:0];
                if (vel[fps_pkg::VEL_W-1] && !apogee_seen_reg)
                begin
                    phase_next       = fps_pkg::PH_APOGEE;
                    apogee_seen_next = 1'b1;
                end
            end
            fps_pkg::PH_APOGEE:
            begin
                if (!cam_one_running_reg)
                begin
                    result.cam_one_start = 1'b1;
                    cam_one_running_next = 1'b1;
                end
                phase_next = fps_pkg::PH_DESCENT;
            end
            fps_pkg::PH_DESCENT:
            begin
                if (hit_descent)
                    phase_next = fps_pkg::PH_PROBE;
            end
            fps_pkg::PH_PROBE:
            begin
                if (hit_release)
                    phase_next = fps_pkg::PH_PAYLOAD;
            end
            fps_pkg::PH_PAYLOAD:
            begin
                if (hit_landed)
                    phase_next = fps_pkg::PH_LANDED;
                if (!cam_two_running_reg)
                begin
                    result.cam_two_start = 1'b1;
                    cam_two_running_next = 1'b1;
                end
            end
            fps_pkg::PH_LANDED:
            begin
                if (cam_one_running_reg)
                begin
                    result.cam_one_stop  = 1'b1;
                    cam_one_running_next = 1'b0;
                end
                if (cam_two_running_reg)
                begin
                    result.cam_two_stop  = 1'b1;
                    cam_two_running_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = fps_pkg::PH_PRELAUNCH;
            end
        endcase

        result.phase = fps_pkg::phase_code(phase_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= fps_pkg::PH_PRELAUNCH;
            peak_reg            <= '0;
            pad_alt_reg         <= '0;
            pad_ready_reg       <= 1'b0;
            apogee_seen_reg     <= 1'b0;
            cam_one_running_reg <= 1'b0;
            cam_two_running_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg           <= phase_next;
            peak_reg            <= peak_next;
            pad_alt_reg         <= pad_alt_next;
            pad_ready_reg       <= pad_ready_next;
            apogee_seen_reg     <= apogee_seen_next;
            cam_one_running_reg <= cam_one_running_next;
            cam_two_running_reg <= cam_two_running_next;
        end
    end

    // Landed is terminal until reset
    a_landed_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == fps_pkg::PH_LANDED |=> phase_reg == fps_pkg::PH_LANDED)
        else $error("left landed phase");

    // Peak altitude never drops
    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("peak altitude decreased");

    // Zero request only on the first pad tick
    a_zero_first_pad: assert property (@(posedge clk) disable iff (!rst_n)
        result.zero_request |-> (phase_reg == fps_pkg::PH_PAD) && !pad_ready_reg)
        else $error("zero request outside first pad tick");

    // A landed tick leaves both cameras stopped
    a_landed_cams_off: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (phase_reg == fps_pkg::PH_LANDED)
        |=> !cam_one_running_reg && !cam_two_running_reg)
        else $error("camera still running after landed tick");

    // Apogee entry sets the latch
    a_apogee_latch: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == fps_pkg::PH_APOGEE) |-> apogee_seen_reg)
        else $error("apogee entered without latch");

endmodule

/* design/flight_phase_sequencer_core.sv */
// Top level of the flight phase sequencer: stream ports, input and result registers.
// Depends on fps_pkg, fps_cfg and fps_seq.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid/tready      | s_axis_tdata[39:0], one sensor tick
// m_axis    | out       | m_axis_tvalid/tready      | m_axis_tdata[15:0], one result
// cfg       | in        | cfg_wr_en (no wait)       | cfg_index[1:0], cfg_wdata[13:0]
//
// Every tick yields exactly one result. A tick is held in the input
// register, is stepped through the phase logic and lands in the result
// register; one transaction per cycle is sustained while m_axis is ready.
// Reset (rst_n low, asynchronous) empties both registers, returns the phase to
// prelaunch and restores register defaults. A stall on m_axis holds the
// result and the pending tick; s_axis_tready drops only when both are full.

module flight_phase_sequencer_core (
    input  logic                               clk,
    input  logic                               rst_n,

    // altitude[17:0], vertical_speed[34:18], link_up[35], clock_set[36], zero[39:37]
    input  logic [fps_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,

    // phase[2:0], zero_request[3], servo_reset[4], cam_one_start[5],
    // cam_two_start[6], cam_one_stop[7], cam_two_stop[8], zero[15:9]
    output logic [fps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,

    input  logic                               cfg_wr_en,
    input  logic [fps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    fps_pkg::cfg_t    cfg;
    fps_pkg::item_t   in_item_reg, in_item_next;
    logic             in_valid_reg, in_valid_next;
    fps_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    fps_pkg::result_t step_result;

    logic in_accept;
    logic out_accept;
    logic advance;

    fps_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    fps_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cfg     (cfg),
        .item    (in_item_reg),
        .result  (step_result)
    );

    // Advance the held tick whenever the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_axis_tvalid && m_axis_tready;

    // Unpack the incoming transaction
    always_comb
    begin
        in_item_next = in_item_reg;
        if (in_accept)
        begin
            in_item_next.altitude       = $signed(s_axis_tdata[17:0]);
            in_item_next.vertical_speed = $signed(s_axis_tdata[34:18]);
            in_item_next.link_up        = s_axis_tdata[35];
            in_item_next.clock_set      = s_axis_tdata[36];
        end
    end

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = step_result;
        end
        else
        begin
            out_valid_next = out_accept ? 1'b0 : out_valid_reg;
            out_next       = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_reg     <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0,
                            out_reg.cam_two_stop,
                            out_reg.cam_one_stop,
                            out_reg.cam_two_start,
                            out_reg.cam_one_start,
                            out_reg.servo_reset,
                            out_reg.zero_request,
                            out_reg.phase};

    // A held tick must move on once the result side is free
    a_no_stuck_tick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("held tick did not advance");

    // A stalled result is not overwritten
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");

    // Input side stalls only when both stages are full
    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled with room available");

endmodule
